### rtl/core/gha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg: shared definitions of the generational handle allocator
// Field widths of the command and result channels, command codes and
// status codes.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Field widths of the channel payloads.
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int GEN_W    = 16;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ATTACHED  = 2'd3;

endpackage
`default_nettype wire

### rtl/core/gha_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gha_cmd_if: command channel of the handle allocator
// Valid/ready channel carrying one handle command per transfer.
// ----------------------------------------------------------------------------
interface gha_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::CMD_W-1:0]   command;
  logic [gha_pkg::SLOT_W-1:0]  handle_slot;
  logic [gha_pkg::GEN_W-1:0]   handle_generation;
  logic                        still_attached;

  modport source (
    output valid, command, handle_slot, handle_generation, still_attached,
    input  ready
  );
  modport sink (
    input  valid, command, handle_slot, handle_generation, still_attached,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/gha_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gha_res_if: result channel of the handle allocator
// Valid/ready channel carrying one command result per transfer.
// ----------------------------------------------------------------------------
interface gha_res_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [gha_pkg::SLOT_W-1:0]    out_slot;
  logic [gha_pkg::GEN_W-1:0]     out_generation;

  modport source (
    output valid, status, out_slot, out_generation,
    input  ready
  );
  modport sink (
    input  valid, status, out_slot, out_generation,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/gha_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gha_slot_table: per-slot generation and occupied mark
// Synchronous memory with a registered read port; a write to the entry
// being read in the same cycle is forwarded into the read register.
// ----------------------------------------------------------------------------
module gha_slot_table #(
  parameter int SLOTS    = 64,
  parameter int GEN_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rd_en,
  input  wire  [$clog2(SLOTS)-1:0]   rd_addr,
  input  wire                        wr_en,
  input  wire  [$clog2(SLOTS)-1:0]   wr_addr,
  input  wire                        wr_occ,
  input  wire  [GEN_BITS-1:0]        wr_gen,
  output logic                       rd_occ,
  output logic [GEN_BITS-1:0]        rd_gen
);

  logic [GEN_BITS:0] mem [SLOTS];
  logic [GEN_BITS:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_occ, wr_gen};
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= {wr_occ, wr_gen};
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_occ = rd_data_r[GEN_BITS];
  assign rd_gen = rd_data_r[GEN_BITS-1:0];

endmodule
`default_nettype wire

### rtl/core/gha_free_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gha_free_stack: LIFO of freed slots
// Each entry keeps the slot and the generation it will carry when handed
// out again. The top of stack is prefetched into a register when a command
// is taken, with forwarding of a push made in the same cycle.
// ----------------------------------------------------------------------------
module gha_free_stack #(
  parameter int SLOTS    = 64,
  parameter int GEN_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            rd_en,
  input  wire                            push,
  input  wire  [$clog2(SLOTS)-1:0]       push_slot,
  input  wire  [GEN_BITS-1:0]            push_gen,
  input  wire                            pop,
  output logic [$clog2(SLOTS)-1:0]       top_slot,
  output logic [GEN_BITS-1:0]            top_gen,
  output logic [$clog2(SLOTS+1)-1:0]     count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = IDX_W + GEN_BITS;

  logic [ENT_W-1:0] mem [SLOTS];
  logic [ENT_W-1:0] top_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push_ok;
  logic             pop_ok;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;

  // A push onto a full stack is dropped; a pop of an empty one is ignored.
  assign push_ok = push && (count_r < CNT_W'(SLOTS));
  assign pop_ok  = pop && (count_r != '0);
  assign waddr   = IDX_W'(count_r);

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign raddr = IDX_W'(count_nxt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[waddr] <= {push_slot, push_gen};
    end
    if (rd_en) begin
      if (push_ok && (waddr == raddr)) begin
        top_r <= {push_slot, push_gen};
      end else begin
        top_r <= mem[raddr];
      end
    end
  end

  assign top_slot = top_r[ENT_W-1:GEN_BITS];
  assign top_gen  = top_r[GEN_BITS-1:0];
  assign count    = count_r;

endmodule
`default_nettype wire

### rtl/core/generational_handle_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot/generation handle allocator
// Allocates, frees and checks handles made of a slot and a generation.
// ----------------------------------------------------------------------------
// The block sustains one command per cycle while its results are taken. A
// transferred command goes into the execute-stage register, and its result
// into the output register once that register is free; a stalled result
// stalls at most the one command behind it. Throughput is set by the
// read-modify-write of the slot table: the table and the free stack are read
// at the edge where a command is transferred, and written when it leaves the
// execute stage, while the next command is read, with forwarding between the two.
// Slots not yet handed out are recognised by the fresh-slot count, so no
// clearing pass runs after reset and commands are taken at once.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int SLOTS    = 64,
  parameter int GEN_BITS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  gha_cmd_if.sink    in_cmd,
  gha_res_if.source  out_res
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (gha_pkg::SLOT_W > CNT_W) ? gha_pkg::SLOT_W : CNT_W;

  // Execute stage: the command whose memory reads are in flight.
  logic                            ex_valid_r;
  logic [gha_pkg::CMD_W-1:0]       ex_cmd_r;
  logic [gha_pkg::SLOT_W-1:0]      ex_slot_r;
  logic [gha_pkg::GEN_W-1:0]       ex_gen_r;
  logic                            ex_att_r;

  // Output register.
  logic                            out_valid_r;
  logic [gha_pkg::STATUS_W-1:0]    out_status_r;
  logic [gha_pkg::SLOT_W-1:0]      out_slot_r;
  logic [gha_pkg::GEN_W-1:0]       out_gen_r;
  logic [gha_pkg::STATUS_W-1:0]    out_status_nxt;
  logic [gha_pkg::SLOT_W-1:0]      out_slot_nxt;
  logic [gha_pkg::GEN_W-1:0]       out_gen_nxt;

  logic [CNT_W-1:0]                fresh_count_r;
  logic                            fresh_take;

  logic                            out_free;
  logic                            ex_go;
  logic                            in_fire;

  // Memory side.
  logic                            tab_we;
  logic [IDX_W-1:0]                tab_waddr;
  logic                            tab_wocc;
  logic [GEN_BITS-1:0]             tab_wgen;
  logic                            tab_rocc;
  logic [GEN_BITS-1:0]             tab_rgen;
  logic                            stk_push;
  logic                            stk_pop;
  logic [IDX_W-1:0]                stk_top_slot;
  logic [GEN_BITS-1:0]             stk_top_gen;
  logic [CNT_W-1:0]                free_count;

  // Decode of the executing command.
  logic [GEN_BITS-1:0]             gen_cmp;
  logic [IDX_W-1:0]                slot_idx;
  logic                            in_range;
  logic                            current;
  logic [GEN_BITS-1:0]             gen_bump;

  // The output register is free when empty or when its result is taken now.
  // The execute stage moves on when the output register can take its result,
  // and a new command enters when the stage is empty or as the executing one leaves.
  assign out_free     = !out_valid_r || out_res.ready;
  assign ex_go        = ex_valid_r && out_free;
  assign in_cmd.ready = !ex_valid_r || out_free;
  assign in_fire      = in_cmd.valid && in_cmd.ready;

  gha_slot_table #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_slot_table (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (IDX_W'(in_cmd.handle_slot)),
    .wr_en   (tab_we),
    .wr_addr (tab_waddr),
    .wr_occ  (tab_wocc),
    .wr_gen  (tab_wgen),
    .rd_occ  (tab_rocc),
    .rd_gen  (tab_rgen)
  );

  gha_free_stack #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .push      (stk_push),
    .push_slot (slot_idx),
    .push_gen  (gen_bump),
    .pop       (stk_pop),
    .top_slot  (stk_top_slot),
    .top_gen   (stk_top_gen),
    .count     (free_count)
  );

  // Only the low GEN_BITS bits of the handle's generation take part in the
  // check. A slot at or above the fresh count has never been handed out, so
  // its table entry is never consulted; this also covers slots beyond the
  // pool. A generation of zero never matches.
  assign gen_cmp  = GEN_BITS'(ex_gen_r);
  assign slot_idx = IDX_W'(ex_slot_r);
  assign in_range = CMP_W'(ex_slot_r) < CMP_W'(fresh_count_r);
  assign current  = (gen_cmp != '0) && in_range && tab_rocc && (tab_rgen == gen_cmp);

  // Generation after a free: count up, skipping zero on wrap.
  always_comb begin
    gen_bump = tab_rgen + GEN_BITS'(1);
    if (gen_bump == '0) begin
      gen_bump = GEN_BITS'(1);
    end
  end

  always_comb begin
    out_status_nxt = gha_pkg::ST_STALE;
    out_slot_nxt   = ex_slot_r;
    out_gen_nxt    = ex_gen_r;
    tab_we         = 1'b0;
    tab_waddr      = slot_idx;
    tab_wocc       = 1'b0;
    tab_wgen       = gen_bump;
    stk_push       = 1'b0;
    stk_pop        = 1'b0;
    fresh_take     = 1'b0;
    unique case (ex_cmd_r)
      gha_pkg::CMD_ALLOC: begin
        if (free_count != '0) begin
          // Reuse the most recently freed slot, with the generation it was
          // given when it was freed.
          stk_pop        = ex_go;
          tab_we         = ex_go;
          tab_waddr      = stk_top_slot;
          tab_wocc       = 1'b1;
          tab_wgen       = stk_top_gen;
          out_status_nxt = gha_pkg::ST_OK;
          out_slot_nxt   = gha_pkg::SLOT_W'(stk_top_slot);
          out_gen_nxt    = gha_pkg::GEN_W'(stk_top_gen);
        end else if (fresh_count_r < CNT_W'(SLOTS)) begin
          // A fresh slot is handed out with generation one.
          fresh_take     = ex_go;
          tab_we         = ex_go;
          tab_waddr      = IDX_W'(fresh_count_r);
          tab_wocc       = 1'b1;
          tab_wgen       = GEN_BITS'(1);
          out_status_nxt = gha_pkg::ST_OK;
          out_slot_nxt   = gha_pkg::SLOT_W'(fresh_count_r);
          out_gen_nxt    = gha_pkg::GEN_W'(1);
        end else begin
          out_status_nxt = gha_pkg::ST_EXHAUSTED;
          out_slot_nxt   = '0;
          out_gen_nxt    = '0;
        end
      end
      gha_pkg::CMD_FREE: begin
        if (!current) begin
          out_status_nxt = gha_pkg::ST_STALE;
        end else if (ex_att_r) begin
          out_status_nxt = gha_pkg::ST_ATTACHED;
        end else begin
          tab_we         = ex_go;
          tab_wocc       = 1'b0;
          stk_push       = ex_go;
          out_status_nxt = gha_pkg::ST_OK;
        end
      end
      gha_pkg::CMD_LOOKUP: begin
        out_status_nxt = current ? gha_pkg::ST_OK : gha_pkg::ST_STALE;
      end
      default: begin
        out_status_nxt = gha_pkg::ST_STALE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      fresh_count_r <= '0;
    end else begin
      if (in_fire) begin
        ex_valid_r <= 1'b1;
      end else if (ex_go) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_go) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fresh_take) begin
        fresh_count_r <= fresh_count_r + CNT_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_cmd_r  <= in_cmd.command;
      ex_slot_r <= in_cmd.handle_slot;
      ex_gen_r  <= in_cmd.handle_generation;
      ex_att_r  <= in_cmd.still_attached;
    end
    if (ex_go) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_gen_r    <= out_gen_nxt;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = out_status_r;
  assign out_res.out_slot       = out_slot_r;
  assign out_res.out_generation = out_gen_r;

  // Every slot on the free stack was handed out fresh at some point.
  a_free_within_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    free_count <= fresh_count_r)
    else $error("free stack holds more slots than were ever handed out");

  // The fresh count never passes the pool size.
  a_fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_count_r <= CNT_W'(SLOTS))
    else $error("fresh slot count beyond pool size");

  // A command waiting on a full output register keeps its place.
  a_ex_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid_r && !out_free) |=> (ex_valid_r && $stable(ex_cmd_r) && $stable(ex_slot_r)))
    else $error("stalled command left the execute stage");

  // An allocation from an empty stack takes exactly one fresh slot.
  a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_go && (ex_cmd_r == gha_pkg::CMD_ALLOC) && (free_count == '0) &&
     (fresh_count_r < CNT_W'(SLOTS)))
    |=> (fresh_count_r == $past(fresh_count_r) + CNT_W'(1)))
    else $error("fresh allocation did not advance the fresh count");

  // A completed free grows the stack by one entry.
  a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
    stk_push |=> (free_count == $past(free_count) + CNT_W'(1)))
    else $error("successful free did not push its slot");

endmodule
`default_nettype wire

### test/handle_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handle_table_checker: result checker of the generational handle allocator
// Watches both channels, keeps its own copy of the slot table, free stack
// and fresh-slot count, and compares each result transfer with the oldest
// predicted reply.
// ----------------------------------------------------------------------------
module handle_table_checker (
  input  wire          clk,
  input  wire          rst_n,
  gha_cmd_if           cmd,
  gha_res_if           res,
  output int unsigned  fail_count,
  output int unsigned  pending
);
  import gha_pkg::*;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [GEN_W-1:0]    gen;
  } reply_t;

  logic [GEN_W-1:0]  slot_gen [SLOTS];
  logic              slot_busy [SLOTS];
  logic [SLOT_W-1:0] free_lifo [SLOTS];
  int unsigned       lifo_depth;
  int unsigned       fresh_used;
  int unsigned       errors;
  reply_t            awaited_replies [$];

  // A handle is current when its slot has been handed out, is in use and
  // carries the same non-zero generation.
  function automatic logic is_current(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
    if (g == '0 || s >= fresh_used) return 1'b0;
    return slot_busy[s] && slot_gen[s] == g;
  endfunction

  // Applies one command to the shadow state and returns the reply it earns.
  function automatic reply_t predict_handle_op(logic [CMD_W-1:0] op,
                                               logic [SLOT_W-1:0] hs,
                                               logic [GEN_W-1:0] hg,
                                               logic att);
    reply_t           r;
    logic [SLOT_W-1:0] s;
    logic [GEN_W-1:0]  next_gen;
    r = '{status: ST_STALE, slot: hs, gen: hg};
    case (op)
      CMD_ALLOC: begin
        if (lifo_depth > 0) begin
          lifo_depth--;
          s = free_lifo[lifo_depth];
        end else if (fresh_used < SLOTS) begin
          s = SLOT_W'(fresh_used);
          fresh_used++;
        end else begin
          return '{status: ST_EXHAUSTED, slot: '0, gen: '0};
        end
        slot_busy[s] = 1'b1;
        r = '{status: ST_OK, slot: s, gen: slot_gen[s]};
      end
      CMD_FREE: begin
        if (is_current(hs, hg)) begin
          if (att) begin
            r.status = ST_ATTACHED;
          end else begin
            slot_busy[hs] = 1'b0;
            next_gen = slot_gen[hs] + 1'b1;
            if (next_gen == '0) next_gen = GEN_W'(1);
            slot_gen[hs] = next_gen;
            if (lifo_depth < SLOTS) begin
              free_lifo[lifo_depth] = hs;
              lifo_depth++;
            end
            r.status = ST_OK;
          end
        end
      end
      CMD_LOOKUP: begin
        if (is_current(hs, hg)) r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_field(input string field, input logic [GEN_W-1:0] want,
                              input logic [GEN_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_gen[i]  = GEN_W'(1);
        slot_busy[i] = 1'b0;
        free_lifo[i] = '0;
      end
      lifo_depth = 0;
      fresh_used = 0;
      errors     = 0;
      awaited_replies.delete();
    end else begin
      // A result can never belong to a command transferred at the same edge,
      // so the result side is handled first.
      if (res.valid && res.ready) begin
        got = '{status: res.status, slot: res.out_slot, gen: res.out_generation};
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d slot %0d gen %0d",
                   $time, got.status, got.slot, got.gen);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status) report_field("status", want.status, got.status);
          if (got.slot !== want.slot) report_field("out_slot", want.slot, got.slot);
          if (got.gen !== want.gen) report_field("out_generation", want.gen, got.gen);
        end
      end
      if (cmd.valid && cmd.ready) begin
        want = predict_handle_op(cmd.command, cmd.handle_slot,
                                 cmd.handle_generation, cmd.still_attached);
        awaited_replies = {awaited_replies, want};
      end
    end
    fail_count <= errors;
    pending    <= awaited_replies.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level of the generational handle allocator testbench
// Drives handle commands into the allocator, keeps a list of the handles it
// has been given so that most commands are meaningful, and gives the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;
  import gha_pkg::*;

  // The command code that the block does not know; it must answer stale.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The longest legitimate quiet stretch is the receiver hold-off below.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 630;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    handle_t          h;
    logic             att;
  } issued_t;

  logic clk;
  logic rst_n;

  gha_cmd_if cmd_ch ();
  gha_res_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // Idling percentages of the sender and of the receiver, set per phase.
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 79;

  // The stimulus asks for a receiver hold-off by bumping hold_req; the
  // receiver process answers by bumping hold_done once it has held off.
  int unsigned hold_req  = 0;
  int unsigned hold_done = 0;

  // Handles known to be current, handles known to be stale, and the
  // commands whose results are still on their way.
  handle_t     live_q [$];
  handle_t     retired_q [$];
  issued_t     issued_q [$];
  int unsigned exhausted_seen = 0;
  int unsigned exhausted_mark = 0;
  logic        draining = 1'b0;

  generational_handle_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_ch),
    .out_res (res_ch)
  );

  handle_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic handle_t mk_handle(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
    return '{slot: s, gen: g};
  endfunction

  function automatic int find_live(handle_t h);
    for (int i = 0; i < live_q.size(); i++)
      if (live_q[i] == h) return i;
    return -1;
  endfunction

  // Offers one command, possibly after idling first, and returns at the
  // falling edge after its transfer. Valid is left high, so that the next
  // command follows without a gap unless the next call chooses to idle.
  task automatic send(input logic [CMD_W-1:0] op, input handle_t h, input logic att);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid             <= 1'b1;
    cmd_ch.command           <= op;
    cmd_ch.handle_slot       <= h.slot;
    cmd_ch.handle_generation <= h.gen;
    cmd_ch.still_attached    <= att;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    issued_q = {issued_q, issued_t'{op: op, h: h, att: att}};
    @(negedge clk);
  endtask

  // One random command. The stimulus alternates between filling the pool
  // until it reports exhaustion and draining it until no handle is left, so
  // that both the fresh-slot path and the free stack are worked hard.
  task automatic random_item();
    int unsigned pick;
    int unsigned alloc_pct;
    int          idx;
    handle_t     h;
    logic        att;
    pick = $urandom_range(99);
    h    = mk_handle(SLOT_W'($urandom), GEN_W'($urandom));
    att  = 1'($urandom);
    if (!draining && exhausted_seen != exhausted_mark) begin
      draining = 1'b1;
    end else if (draining && live_q.size() == 0) begin
      draining       = 1'b0;
      exhausted_mark = exhausted_seen;
    end
    alloc_pct = draining ? 15 : 55;
    if (pick < alloc_pct) begin
      // Allocation ignores the handle fields, so they carry random bits.
      send(CMD_ALLOC, h, att);
    end else if (pick < 70 && live_q.size() > 0) begin
      // Free a current handle; one in five is refused as still attached and
      // therefore stays in the list.
      idx = $urandom_range(live_q.size() - 1);
      h   = live_q[idx];
      att = ($urandom_range(4) == 0);
      if (!att) live_q.delete(idx);
      send(CMD_FREE, h, att);
    end else if (pick < 88 && live_q.size() > 0) begin
      // Look up a current handle, now and then with one generation bit flipped.
      h = live_q[$urandom_range(live_q.size() - 1)];
      if ($urandom_range(4) == 0) h.gen ^= GEN_W'(1) << $urandom_range(GEN_W - 1);
      send(CMD_LOOKUP, h, att);
    end else if (pick < 94 && retired_q.size() > 0) begin
      // A handle whose slot has since been freed: a double free or a stale look-up.
      h = retired_q[$urandom_range(retired_q.size() - 1)];
      send($urandom_range(1) ? CMD_FREE : CMD_LOOKUP, h, att);
    end else begin
      // Noise: random handles, mostly unknown, and the undefined command.
      case ($urandom_range(2))
        0:       send(CMD_FREE, h, att);
        1:       send(CMD_LOOKUP, h, att);
        default: send(CMD_UNDEFINED, h, att);
      endcase
    end
  endtask

  // Learns from the results which handles are current. This only steers the
  // stimulus; all checking is done by the checker.
  always @(posedge clk) begin
    issued_t c;
    handle_t h;
    int      idx;
    if (rst_n && res_ch.valid && res_ch.ready && issued_q.size() > 0) begin
      c = issued_q.pop_front();
      h = mk_handle(res_ch.out_slot, res_ch.out_generation);
      if (res_ch.status == ST_EXHAUSTED) exhausted_seen++;
      if (c.op == CMD_ALLOC && res_ch.status == ST_OK) begin
        live_q = {live_q, h};
      end else if (c.op == CMD_FREE) begin
        idx = find_live(h);
        if (res_ch.status == ST_OK) begin
          if (idx >= 0) live_q.delete(idx);
          retired_q = {retired_q, h};
          if (retired_q.size() > 64) void'(retired_q.pop_front());
        end else if (res_ch.status == ST_ATTACHED && idx < 0) begin
          live_q = {live_q, h};
        end
      end
    end
  end

  // Receiver: accepts results at random, and on request holds off for a long
  // stretch so that the block fills up and stops taking commands.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if neither channel sees a transfer for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL generational_handle_allocator");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    rst_n                    = 1'b0;
    cmd_ch.valid             = 1'b0;
    cmd_ch.command           = CMD_ALLOC;
    cmd_ch.handle_slot       = '0;
    cmd_ch.handle_generation = '0;
    cmd_ch.still_attached    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Straight after reset no slot has been handed out, so
    // every handle is unknown, even one whose generation is the reset value.
    send(CMD_LOOKUP, mk_handle(0, 1), 1'b0);
    // An unknown handle is refused as stale even when marked attached.
    send(CMD_FREE, mk_handle('1, '1), 1'b1);
    send(CMD_UNDEFINED, mk_handle('1, '1), 1'b1);
    // Empty free stack: fresh slots 0, 1 and 2 come out with generation one.
    send(CMD_ALLOC, mk_handle(0, 0), 1'b0);
    send(CMD_ALLOC, mk_handle(0, 0), 1'b0);
    send(CMD_ALLOC, mk_handle(0, 0), 1'b0);
    send(CMD_LOOKUP, mk_handle(0, 1), 1'b0);
    // Generation zero never matches; a wrong generation is stale.
    send(CMD_LOOKUP, mk_handle(0, 0), 1'b0);
    send(CMD_LOOKUP, mk_handle(0, 2), 1'b0);
    // Slot beyond the fresh-slot count.
    send(CMD_LOOKUP, mk_handle(3, 1), 1'b0);
    // A current handle still attached elsewhere cannot be freed.
    send(CMD_FREE, mk_handle(1, 1), 1'b1);
    send(CMD_FREE, mk_handle(1, 1), 1'b0);
    // The freed slot now carries the next generation but is not in use.
    send(CMD_LOOKUP, mk_handle(1, 2), 1'b0);
    // Double free.
    send(CMD_FREE, mk_handle(1, 1), 1'b0);
    send(CMD_FREE, mk_handle(0, 1), 1'b0);
    // The free stack is last in, first out: slot 0 comes back before slot 1,
    // and only then is a fresh slot taken again.
    send(CMD_ALLOC, mk_handle(0, 0), 1'b0);
    send(CMD_ALLOC, mk_handle(0, 0), 1'b0);
    send(CMD_ALLOC, mk_handle(0, 0), 1'b0);
    send(CMD_LOOKUP, mk_handle(1, 2), 1'b0);
    send(CMD_UNDEFINED, mk_handle(0, 0), 1'b0);
    send(CMD_LOOKUP, mk_handle('1, '1), 1'b1);

    // Random part in three phases: sender mostly busy and receiver mostly
    // idle, then the other way round, then no idling at all. The last phase
    // opens with a long receiver hold-off while commands keep coming.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req++;
        end
      endcase
      repeat (RANDOM_ITEMS / 3) random_item();
    end

    // Let every outstanding result arrive, then keep watching for anything
    // unexpected to show up before the verdict.
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS generational_handle_allocator");
    else
      $display("FAIL generational_handle_allocator");
    $finish;
  end

endmodule
